// ----- design/usv_pkg.sv -----
// shared types, constants and byte classification for the utf-8 stream validator
// no dependencies; imported by the front, back and top modules of the block
package usv_pkg;

  // default cap on the symbol count, before clipping to the field width
  localparam longint unsigned USV_MAX_MESSAGE_BYTES = 64'd65536;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 17;

  // largest value the symbol count field can hold
  localparam longint unsigned COUNT_FIELD_MAX = 64'h1FFFF;

  // depth of the queues between stages
  localparam int unsigned QUEUE_DEPTH = 2;

  // byte masks and patterns
  localparam logic [BYTE_W-1:0] MASK_1 = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_2 = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_3 = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_4 = 8'hF8;
  localparam logic [BYTE_W-1:0] MASK_C = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_1  = 8'h00;
  localparam logic [BYTE_W-1:0] PAT_2  = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_3  = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_4  = 8'hF0;
  localparam logic [BYTE_W-1:0] PAT_C  = 8'h80;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_BAD_LEAD  = 2'd1,
    STATUS_BAD_CONT  = 2'd2,
    STATUS_TRUNCATED = 2'd3
  } status_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       lead_bad;     // not a legal lead byte
    logic [1:0] lead_follow;  // continuation bytes owed after this lead
    logic       cont_ok;      // byte has the form 10xxxxxx
    logic       last;         // final byte of the message
  } byte_class_t;

  // one result item
  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   symbol_count;
  } result_t;

  // classify one byte by its top bits
  function automatic byte_class_t classify(input logic [BYTE_W-1:0] b, input logic last);
    byte_class_t c;
    c.lead_bad    = 1'b0;
    c.lead_follow = 2'd0;
    c.cont_ok     = ((b & MASK_C) == PAT_C);
    c.last        = last;
    if ((b & MASK_1) == PAT_1) begin
      c.lead_follow = 2'd0;
    end else if ((b & MASK_2) == PAT_2) begin
      c.lead_follow = 2'd1;
    end else if ((b & MASK_3) == PAT_3) begin
      c.lead_follow = 2'd2;
    end else if ((b & MASK_4) == PAT_4) begin
      c.lead_follow = 2'd3;
    end else begin
      c.lead_bad = 1'b1;
    end
    return c;
  endfunction

endpackage

// ----- design/utf8_stream_validator_core.sv -----
// UTF-8 stream validator. Bytes of a message enter one per cycle through a queue-style
// push/full port, the final byte marked by in_end_of_message; on that byte one result
// (status and count of complete symbols before the end or first error) appears on the
// pop/empty port. A byte is accepted every cycle as long as results are popped; a
// transfer passes from push to result through the front classification register,
// the two-entry queue to the state-tracking back stage, and the two-entry result queue.
// The back stage holds a final byte only while the result queue is full.
// Overlong and surrogate forms are not rejected; the symbol count saturates at
// MAX_MESSAGE_BYTES or 131071, whichever is smaller.
module utf8_stream_validator_core import usv_pkg::*; #(
  parameter longint unsigned MAX_MESSAGE_BYTES = USV_MAX_MESSAGE_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_end_of_message,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [1:0]         out_status,
  output logic [COUNT_W-1:0] out_symbol_count
);

  localparam int unsigned CLS_W = $bits(byte_class_t);
  localparam int unsigned RES_W = $bits(result_t);

  logic        fr_valid;
  byte_class_t fr_data;
  logic        mid_full, mid_empty, mid_pop;
  logic [CLS_W-1:0] mid_data;
  byte_class_t mid_cls;
  logic        res_push, res_full;
  result_t     res_in, res_out;
  logic [RES_W-1:0] res_out_bits;

  // byte classification
  usv_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .in_full           (in_full),
    .cls_valid         (fr_valid),
    .cls_data          (fr_data),
    .cls_full          (mid_full)
  );

  // queue between front and back
  usv_queue #(
    .DATA_W (CLS_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_valid),
    .push_data (fr_data),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_data),
    .empty     (mid_empty)
  );

  assign mid_cls = byte_class_t'(mid_data);

  // sequence state and result generation
  usv_back #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_empty (mid_empty),
    .cls_data  (mid_cls),
    .cls_pop   (mid_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  // result queue
  usv_queue #(
    .DATA_W (RES_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_out_bits),
    .empty     (out_empty)
  );

  assign res_out          = result_t'(res_out_bits);
  assign out_status       = res_out.status;
  assign out_symbol_count = res_out.symbol_count;

endmodule

// ----- design/usv_queue.sv -----
// small first-in first-out queue with full and empty flags
// depends on nothing but its parameters; used between front, back and output
module usv_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/usv_front.sv -----
// front stage: takes raw bytes and registers their classification
// depends on usv_pkg for the classification function and byte_class_t
module usv_front import usv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_message,
  output logic              in_full,
  output logic              cls_valid,
  output byte_class_t       cls_data,
  input  logic              cls_full
);

  logic        vld_r, vld_nxt;
  byte_class_t cls_r, cls_nxt;
  logic        advance;

  // stage moves when empty or its item is taken downstream
  assign advance   = !vld_r || !cls_full;
  assign in_full   = !advance;
  assign cls_valid = vld_r;
  assign cls_data  = cls_r;

  always_comb begin
    vld_nxt = vld_r;
    cls_nxt = cls_r;
    if (advance) begin
      vld_nxt = in_push;
      cls_nxt = classify(in_data_byte, in_end_of_message);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

endmodule

// ----- design/usv_back.sv -----
// back stage: tracks sequence state and symbol count, emits one result per message
// depends on usv_pkg for byte_class_t, result_t and status codes
module usv_back import usv_pkg::*; #(
  parameter longint unsigned MAX_MESSAGE_BYTES = USV_MAX_MESSAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cls_empty,
  input  byte_class_t cls_data,
  output logic        cls_pop,
  output logic        res_push,
  output result_t     res_data,
  input  logic        res_full
);

  localparam logic [COUNT_W-1:0] COUNT_CAP = (MAX_MESSAGE_BYTES > COUNT_FIELD_MAX) ?
      COUNT_W'(COUNT_FIELD_MAX) : COUNT_W'(MAX_MESSAGE_BYTES);

  logic [1:0]         expect_r, expect_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  status_t            err_r, err_nxt;
  logic [1:0]         exp_upd;
  logic [COUNT_W-1:0] cnt_upd;
  status_t            err_upd;
  logic               count_one;

  // a final byte waits until the result queue has room
  assign cls_pop = !cls_empty && (!cls_data.last || !res_full);

  // sequence tracking per transfer
  always_comb begin
    exp_upd   = expect_r;
    err_upd   = err_r;
    count_one = 1'b0;
    if (err_r == STATUS_VALID) begin
      if (expect_r == 2'd0) begin
        if (cls_data.lead_bad || cls_data.cont_ok) begin
          err_upd = STATUS_BAD_LEAD;
        end else if (cls_data.lead_follow == 2'd0) begin
          count_one = 1'b1;
        end else begin
          exp_upd = cls_data.lead_follow;
        end
      end else if (cls_data.cont_ok) begin
        exp_upd   = expect_r - 2'd1;
        count_one = (expect_r == 2'd1);
      end else begin
        err_upd = STATUS_BAD_CONT;
      end
    end
    cnt_upd = (count_one && (count_r < COUNT_CAP)) ? count_r + COUNT_W'(1) : count_r;
  end

  // result on the final byte, then state returns to reset
  always_comb begin
    expect_nxt            = expect_r;
    count_nxt             = count_r;
    err_nxt               = err_r;
    res_push              = 1'b0;
    res_data.symbol_count = cnt_upd;
    if (err_upd != STATUS_VALID) begin
      res_data.status = err_upd;
    end else if (exp_upd != 2'd0) begin
      res_data.status = STATUS_TRUNCATED;
    end else begin
      res_data.status = STATUS_VALID;
    end
    if (cls_pop) begin
      if (cls_data.last) begin
        res_push   = 1'b1;
        expect_nxt = 2'd0;
        count_nxt  = '0;
        err_nxt    = STATUS_VALID;
      end else begin
        expect_nxt = exp_upd;
        count_nxt  = cnt_upd;
        err_nxt    = err_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 2'd0;
      count_r  <= '0;
      err_r    <= STATUS_VALID;
    end else begin
      expect_r <= expect_nxt;
      count_r  <= count_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// ----- tb/sv/utf8_stream_validator_core_test.sv -----
// self-checking testbench for utf8_stream_validator_core: queue-style byte and result ports,
// a built-in validator that predicts each message status and symbol count
// depends on usv_pkg (status codes, field widths, count cap) and the core itself
module utf8_stream_validator_core_test;
  import usv_pkg::*;

  // symbol count stops at the message cap or the field limit, whichever is lower
  localparam longint unsigned COUNT_CAP =
    (USV_MAX_MESSAGE_BYTES < COUNT_FIELD_MAX) ? USV_MAX_MESSAGE_BYTES : COUNT_FIELD_MAX;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eom;
  } byte_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic [BYTE_W-1:0]  in_data_byte = '0;
  logic               in_end_of_message = 1'b0;
  logic               in_full;
  logic               out_pop = 1'b0;
  logic               out_empty;
  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_symbol_count;

  // bytes waiting to be pushed, and the message under construction
  byte_item_t        pending[$];
  logic [BYTE_W-1:0] msg_bytes[$];
  // message verdicts still owed by the block
  result_t           expected_verdicts[$];

  // validator state mirrored from accepted bytes
  logic [1:0]         owed_conts = '0;
  logic [COUNT_W-1:0] symbol_tally = '0;
  status_t            first_error = STATUS_VALID;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          failed = 1'b0;

  utf8_stream_validator_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .in_full           (in_full),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_status        (out_status),
    .out_symbol_count  (out_symbol_count)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // timeout
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // saturating symbol count
  function automatic void tally_symbol();
    if (symbol_tally < COUNT_CAP) begin
      symbol_tally = symbol_tally + 1'b1;
    end
  endfunction

  // advance the validator by one accepted byte; the final byte yields a verdict
  function automatic void track_byte(input logic [BYTE_W-1:0] b, input logic eom);
    result_t r;
    if (first_error == STATUS_VALID) begin
      if (owed_conts == 2'd0) begin
        if (b[7] == 1'b0) begin
          tally_symbol();
        end else if (b[7:5] == 3'b110) begin
          owed_conts = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          owed_conts = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          owed_conts = 2'd3;
        end else begin
          // lone continuation or a lead with five or more high ones
          first_error = STATUS_BAD_LEAD;
        end
      end else if (b[7:6] == 2'b10) begin
        owed_conts = owed_conts - 1'b1;
        if (owed_conts == 2'd0) begin
          tally_symbol();
        end
      end else begin
        first_error = STATUS_BAD_CONT;
      end
    end
    if (eom) begin
      if (first_error != STATUS_VALID) begin
        r.status = first_error;
      end else if (owed_conts != 2'd0) begin
        r.status = STATUS_TRUNCATED;
      end else begin
        r.status = STATUS_VALID;
      end
      r.symbol_count = symbol_tally;
      expected_verdicts.push_back(r);
      owed_conts   = '0;
      symbol_tally = '0;
      first_error  = STATUS_VALID;
    end
  endfunction

  // driver: push bytes from the pending queue, hold while full
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_data_byte <= '0;
      in_end_of_message <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        track_byte(in_data_byte, in_end_of_message);
        void'(pending.pop_front());
      end
      if (!in_push || !in_full) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_push <= 1'b1;
          in_data_byte <= pending[0].data;
          in_end_of_message <= pending[0].eom;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor: pop at random and compare each transfer with the oldest verdict
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: status %0d symbol_count %0d", out_status, out_symbol_count);
          failed = 1'b1;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            failed = 1'b1;
          end
          if (out_symbol_count !== want.symbol_count) begin
            $error("symbol_count: expected %0d, actual %0d", want.symbol_count,
                   out_symbol_count);
            failed = 1'b1;
          end
        end
      end
      out_pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // byte makers
  function automatic logic [BYTE_W-1:0] lead_byte(input int unsigned len);
    logic [31:0] r;
    r = $urandom;
    case (len)
      1: return {1'b0, r[6:0]};
      2: return {3'b110, r[4:0]};
      3: return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] cont_byte();
    logic [31:0] r;
    r = $urandom;
    return {2'b10, r[5:0]};
  endfunction

  function automatic logic [BYTE_W-1:0] non_cont_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    if (b[7:6] == 2'b10) begin
      b[6] = 1'b1;
    end
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] bad_lead_byte();
    logic [31:0] r;
    r = $urandom;
    return r[8] ? {2'b10, r[5:0]} : {5'b11111, r[2:0]};
  endfunction

  // hand the built message to the driver, end mark on its final byte
  task automatic send_message();
    byte_item_t it;
    foreach (msg_bytes[i]) begin
      it.data = msg_bytes[i];
      it.eom  = (i == msg_bytes.size() - 1);
      pending.push_back(it);
    end
  endtask

  // mostly well-formed text, some with a bad lead, broken sequence, cut end or noise
  task automatic build_random_message();
    int unsigned nsym;
    int unsigned flaw;
    int unsigned spot;
    int unsigned len;
    msg_bytes = {};
    nsym = $urandom_range(1, 6);
    flaw = $urandom_range(0, 9);
    spot = $urandom_range(0, nsym - 1);
    if (flaw == 9) begin
      repeat ($urandom_range(1, 8)) msg_bytes.push_back(BYTE_W'($urandom));
    end else begin
      for (int i = 0; i < nsym; i++) begin
        len = $urandom_range(1, 4);
        if (i == spot && flaw == 6) begin
          msg_bytes.push_back(bad_lead_byte());
        end
        if (i == spot && flaw == 7 && len == 1) begin
          len = $urandom_range(2, 4);
        end
        msg_bytes.push_back(lead_byte(len));
        for (int j = 1; j < len; j++) begin
          if (i == spot && flaw == 7 && j == len - 1) begin
            msg_bytes.push_back(non_cont_byte());
          end else begin
            msg_bytes.push_back(cont_byte());
          end
        end
      end
      // sequence cut short by the end mark
      if (flaw == 8) begin
        len = $urandom_range(2, 4);
        msg_bytes.push_back(lead_byte(len));
        repeat ($urandom_range(0, len - 2)) msg_bytes.push_back(cont_byte());
      end
    end
  endtask

  // wait until every byte is accepted and every verdict has come
  task automatic drain();
    while (pending.size() != 0 || in_push || expected_verdicts.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic run_random_phase(input int unsigned gap, input int unsigned stall);
    int unsigned phase_bytes;
    phase_bytes = 0;
    send_gap_pct = gap;
    stall_pct = stall;
    while (phase_bytes < 100) begin
      build_random_message();
      phase_bytes += msg_bytes.size();
      send_message();
    end
    drain();
  endtask

  // stimulus and end of run
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single bytes at the extremes, lone continuation and long leads
    msg_bytes = '{8'h00}; send_message();
    msg_bytes = '{8'h7F}; send_message();
    msg_bytes = '{8'h80}; send_message();
    msg_bytes = '{8'hFF}; send_message();
    msg_bytes = '{8'hF8}; send_message();
    // one symbol of every length
    msg_bytes = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_message();
    // truncated sequence
    msg_bytes = '{8'hE2, 8'h82}; send_message();
    // broken sequence wins over the cut end
    msg_bytes = '{8'hF0, 8'h9F, 8'h41}; send_message();
    // bytes after an error are ignored
    msg_bytes = '{8'h41, 8'hFF, 8'hC3, 8'hA9}; send_message();
    // lone lead as the only byte
    msg_bytes = '{8'hC0}; send_message();
    drain();

    // random phases, each draining before the next
    run_random_phase(0, 0);
    run_random_phase(61, 0);
    run_random_phase(0, 61);
    run_random_phase(37, 37);

    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
